### sv/bcl_pkg.sv
`default_nettype none
package bcl_pkg;

    localparam int BCL_CAPACITY    = 16;
    localparam int BCL_VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        K_INS_FRONT = 3'd0,
        K_INS_BACK  = 3'd1,
        K_INS_AFTER = 3'd2,
        K_DEL_FRONT = 3'd3,
        K_DEL_BACK  = 3'd4,
        K_DEL_VALUE = 3'd5,
        K_LIST      = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LIST,
        S_SHIFT_UP,
        S_SHIFT_DN
    } t_state;

    // Pointer updates requested by the sequencer
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } t_ptr_cmd;

endpackage
`default_nettype wire

### sv/bcl_ram.sv
`default_nettype none
module bcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/bcl_ptr.sv
`default_nettype none
module bcl_ptr #(
    parameter int CAPACITY = bcl_pkg::BCL_CAPACITY,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bcl_pkg::t_ptr_cmd i_cmd,
    input  wire logic [CW-1:0]    i_rd_idx,
    input  wire logic [CW-1:0]    i_wr_idx,
    output logic      [AW-1:0]    o_rd_addr,
    output logic      [AW-1:0]    o_wr_addr,
    output logic      [AW-1:0]    o_front_prev_addr,
    output logic      [CW-1:0]    o_count
);
    import bcl_pkg::*;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    // Logical position to ring slot: head plus index, wrapped once
    function automatic logic [AW-1:0] map_idx(input logic [AW-1:0] head,
                                              input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(idx);
        if (s >= (CW+1)'(CAPACITY)) begin
            s = s - (CW+1)'(CAPACITY);
        end
        return AW'(s);
    endfunction

    assign o_rd_addr = map_idx(r_head, i_rd_idx);
    assign o_wr_addr = map_idx(r_head, i_wr_idx);
    assign o_front_prev_addr = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign o_count = r_count;

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push_front) begin
            n_head  = o_front_prev_addr;
            n_count = r_count + CW'(1);
        end else if (i_cmd.push_back) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_front) begin
            n_head  = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
            n_count = r_count - CW'(1);
        end else if (i_cmd.pop_back) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

### sv/bounded_circular_list_engine.sv
`default_nettype none
// Ordered list of up to CAPACITY signed values held in a ring buffer RAM.
// Command channel: an item (i_kind, i_new_value, i_search_key) is taken on a
// clock edge with start high and busy low. Results come out one beat per
// cycle on the o_ ports, marked by o_valid; the receiver cannot stall, so
// every beat is taken in the cycle it is shown.
// Insert front/back and remove front/back: the result is registered and shows
// in the cycle after accept; busy stays low, so one such item per cycle.
// Insert after key and remove value: a pipelined scan, one entry per cycle,
// then a move of the later entries one slot per cycle through the single
// write port. The move covers only the entries after the match; a miss
// ends the scan after the last entry has been compared.
// The status beat shows in the cycle busy drops.
// List: count beats, one per cycle, each read from the RAM and registered
// before it shows; the last beat, with o_last, shows in the cycle busy drops.
// An empty list gives one status beat.
// Reset (i_rst_n low, synchronous) empties the list; RAM contents are not
// cleared since slots are only read after being written.
module bounded_circular_list_engine #(
    parameter int CAPACITY    = bcl_pkg::BCL_CAPACITY,
    parameter int VALUE_WIDTH = bcl_pkg::BCL_VALUE_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  i_kind,
    input  wire logic signed [31:0] i_new_value,
    input  wire logic signed [31:0] i_search_key,
    output logic                    o_valid,
    output logic             [1:0]  o_status,
    output logic signed      [31:0] o_entry_value,
    output logic                    o_entry_valid,
    output logic                    o_last,
    output logic             [4:0]  o_occupancy
);
    import bcl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic [VW-1:0] r_val, n_val;
    logic [VW-1:0] r_target, n_target;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_didx, n_didx;
    logic [CW-1:0] r_lo, n_lo;
    logic          r_rvalid, n_rvalid;

    logic          r_ovalid, n_ovalid;
    t_status       r_status, n_status;
    logic signed [31:0] r_evalue, n_evalue;
    logic          r_evalid, n_evalid;
    logic          r_last, n_last;
    logic [4:0]    r_occ, n_occ;

    t_ptr_cmd      ptr_cmd;
    logic [CW-1:0] rd_idx, wr_idx, count, cnt_m1, cnt_p1;
    logic [AW-1:0] rd_addr, wr_addr, front_prev_addr;
    logic          ram_we, use_prev;
    logic [VW-1:0] ram_wdata;
    logic signed [VW-1:0] rdata;
    logic          empty, full, match, dlast;
    t_kind         in_kind;

    bcl_ptr #(.CAPACITY(CAPACITY)) u_ptr (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ptr_cmd),
        .i_rd_idx          (rd_idx),
        .i_wr_idx          (wr_idx),
        .o_rd_addr         (rd_addr),
        .o_wr_addr         (wr_addr),
        .o_front_prev_addr (front_prev_addr),
        .o_count           (count)
    );

    bcl_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (use_prev ? front_prev_addr : wr_addr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign in_kind = t_kind'(i_kind);
    assign empty   = (count == '0);
    assign full    = (count == CW'(CAPACITY));
    assign cnt_m1  = count - CW'(1);
    assign cnt_p1  = count + CW'(1);
    assign match   = (rdata == r_target);
    assign dlast   = (r_didx == cnt_m1);
    assign busy    = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (in_kind)
                        K_INS_AFTER: if (!empty && !full) n_state = S_SCAN;
                        K_DEL_VALUE: if (!empty) n_state = S_SCAN;
                        K_LIST:      if (!empty) n_state = S_LIST;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rvalid) begin
                    if (match) begin
                        n_state = (r_kind == K_INS_AFTER) ? S_SHIFT_UP : S_SHIFT_DN;
                    end else if (dlast) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                if (r_rvalid && dlast) n_state = S_IDLE;
            end
            S_SHIFT_UP: begin
                if (!r_rvalid && r_idx < r_lo) n_state = S_IDLE;
            end
            S_SHIFT_DN: begin
                if (!r_rvalid && r_idx >= count) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_kind    = r_kind;
        n_val     = r_val;
        n_target  = r_target;
        n_idx     = r_idx;
        n_didx    = r_didx;
        n_lo      = r_lo;
        n_rvalid  = 1'b0;
        n_ovalid  = 1'b0;
        n_status  = ST_OK;
        n_evalue  = '0;
        n_evalid  = 1'b0;
        n_last    = 1'b1;
        n_occ     = 5'(count);
        ptr_cmd   = '0;
        rd_idx    = r_idx;
        wr_idx    = '0;
        ram_we    = 1'b0;
        use_prev  = 1'b0;
        ram_wdata = r_val;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind   = in_kind;
                    n_val    = VW'(i_new_value);
                    n_target = (in_kind == K_INS_AFTER) ? VW'(i_search_key)
                                                        : VW'(i_new_value);
                    n_idx    = '0;
                    n_ovalid = 1'b1;
                    ram_wdata = VW'(i_new_value);
                    case (in_kind)
                        K_INS_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                use_prev = 1'b1;
                                ptr_cmd.push_front = 1'b1;
                                n_occ    = 5'(cnt_p1);
                            end
                        end
                        K_INS_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                wr_idx = count;
                                ptr_cmd.push_back = 1'b1;
                                n_occ  = 5'(cnt_p1);
                            end
                        end
                        K_INS_AFTER: begin
                            if (empty)     n_status = ST_EMPTY;
                            else if (full) n_status = ST_FULL;
                            else           n_ovalid = 1'b0;
                        end
                        K_DEL_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ptr_cmd.pop_front = 1'b1;
                                n_occ = 5'(cnt_m1);
                            end
                        end
                        K_DEL_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                ptr_cmd.pop_back = 1'b1;
                                n_occ = 5'(cnt_m1);
                            end
                        end
                        K_DEL_VALUE, K_LIST: begin
                            if (empty) n_status = ST_EMPTY;
                            else       n_ovalid = 1'b0;
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_SCAN, S_LIST: begin
                // Stream reads front to back; the registered RAM data returns in the next cycle
                if (r_idx < count) begin
                    n_idx    = r_idx + CW'(1);
                    n_didx   = r_idx;
                    n_rvalid = 1'b1;
                end
                if (r_rvalid) begin
                    if (r_state == S_LIST) begin
                        n_ovalid = 1'b1;
                        n_evalue = 32'(rdata);
                        n_evalid = 1'b1;
                        n_last   = dlast;
                    end else if (match) begin
                        // Drop the read in flight and start the move
                        n_rvalid = 1'b0;
                        if (r_kind == K_INS_AFTER) begin
                            n_lo  = r_didx + CW'(1);
                            n_idx = cnt_m1;
                        end else begin
                            n_idx = r_didx + CW'(1);
                        end
                    end else if (dlast) begin
                        n_ovalid = 1'b1;
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_SHIFT_UP: begin
                // Move the tail up one slot, back to front, then drop in the value
                if (r_idx >= r_lo) begin
                    n_idx    = r_idx - CW'(1);
                    n_didx   = r_idx;
                    n_rvalid = 1'b1;
                end
                if (r_rvalid) begin
                    ram_we    = 1'b1;
                    wr_idx    = r_didx + CW'(1);
                    ram_wdata = rdata;
                end else if (r_idx < r_lo) begin
                    ram_we   = 1'b1;
                    wr_idx   = r_lo;
                    ptr_cmd.push_back = 1'b1;
                    n_ovalid = 1'b1;
                    n_occ    = 5'(cnt_p1);
                end
            end
            S_SHIFT_DN: begin
                // Close the gap: move each later entry down one slot
                if (r_idx < count) begin
                    n_idx    = r_idx + CW'(1);
                    n_didx   = r_idx;
                    n_rvalid = 1'b1;
                end
                if (r_rvalid) begin
                    ram_we    = 1'b1;
                    wr_idx    = r_didx - CW'(1);
                    ram_wdata = rdata;
                end else if (r_idx >= count) begin
                    ptr_cmd.pop_back = 1'b1;
                    n_ovalid = 1'b1;
                    n_occ    = 5'(cnt_m1);
                end
            end
            default: n_rvalid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rvalid <= n_rvalid;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_val    <= n_val;
        r_target <= n_target;
        r_idx    <= n_idx;
        r_didx   <= n_didx;
        r_lo     <= n_lo;
        r_status <= n_status;
        r_evalue <= n_evalue;
        r_evalid <= n_evalid;
        r_last   <= n_last;
        r_occ    <= n_occ;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_entry_value = r_evalue;
    assign o_entry_valid = r_evalid;
    assign o_last        = r_last;
    assign o_occupancy   = r_occ;

endmodule
`default_nettype wire

### verif/tb_top.sv
module tb_top;
    import bcl_pkg::*;

    localparam int               LIST_CAP  = BCL_CAPACITY;
    localparam logic [2:0]       K_UNUSED  = 3'd7;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int               DRAIN_CYCLES = 2 * LIST_CAP + 8;

    // Shadow copy of the list and the beats each command should produce
    class list_scoreboard;
        typedef struct {
            logic [1:0]         status;
            logic signed [31:0] value;
            logic               valid;
            logic               last;
            logic [4:0]         occ;
        } t_beat;

        logic signed [31:0] entries[$];
        t_beat              expected_beats[$];
        int                 mismatches;
        int                 beats_checked;
        int                 full_answers;
        int                 miss_answers;
        int                 peak_count;

        function void push_beat(logic [1:0] st, logic signed [31:0] v, logic vl, logic ls);
            t_beat b;
            b.status = st;
            b.value  = v;
            b.valid  = vl;
            b.last   = ls;
            b.occ    = 5'(entries.size());
            expected_beats.push_back(b);
        endfunction

        function int find_value(logic signed [31:0] v);
            for (int i = 0; i < entries.size(); i++) begin
                if (entries[i] == v) return i;
            end
            return -1;
        endfunction

        function void note_item(logic [2:0] kind, logic signed [31:0] value,
                                logic signed [31:0] key);
            t_status st;
            int      pos;
            st = ST_OK;
            case (kind)
                K_INS_FRONT, K_INS_BACK: begin
                    if (entries.size() >= LIST_CAP) st = ST_FULL;
                    else if (kind == K_INS_FRONT) entries.push_front(value);
                    else entries.push_back(value);
                end
                K_INS_AFTER: begin
                    if (entries.size() == 0) st = ST_EMPTY;
                    else if (entries.size() >= LIST_CAP) st = ST_FULL;
                    else begin
                        pos = find_value(key);
                        if (pos < 0) st = ST_NOT_FOUND;
                        else entries.insert(pos + 1, value);
                    end
                end
                K_DEL_FRONT, K_DEL_BACK: begin
                    if (entries.size() == 0) st = ST_EMPTY;
                    else if (kind == K_DEL_FRONT) void'(entries.pop_front());
                    else void'(entries.pop_back());
                end
                K_DEL_VALUE: begin
                    if (entries.size() == 0) st = ST_EMPTY;
                    else begin
                        pos = find_value(value);
                        if (pos < 0) st = ST_NOT_FOUND;
                        else entries.delete(pos);
                    end
                end
                K_LIST: begin
                    if (entries.size() == 0) push_beat(ST_EMPTY, '0, 1'b0, 1'b1);
                    for (int i = 0; i < entries.size(); i++)
                        push_beat(ST_OK, entries[i], 1'b1, i == entries.size() - 1);
                    return;
                end
                default: ;
            endcase
            if (st == ST_FULL) full_answers++;
            if (st == ST_NOT_FOUND) miss_answers++;
            if (entries.size() > peak_count) peak_count = entries.size();
            push_beat(st, '0, 1'b0, 1'b1);
        endfunction

        function void check_beat(logic [1:0] st, logic signed [31:0] v, logic vl,
                                 logic ls, logic [4:0] occ);
            t_beat e;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: unexpected beat status=%0d value=%0d",
                              " valid=%0b last=%0b occ=%0d"}, st, v, vl, ls, occ);
                return;
            end
            e = expected_beats.pop_front();
            if (st !== e.status || v !== e.value || vl !== e.valid || ls !== e.last
                    || occ !== e.occ) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"ERROR: beat %0d expected status=%0d value=%0d",
                              " valid=%0b last=%0b occ=%0d"},
                             beats_checked, e.status, e.value, e.valid, e.last, e.occ);
                    $display("       actual   status=%0d value=%0d valid=%0b last=%0b occ=%0d",
                             st, v, vl, ls, occ);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic        [2:0]  i_kind = '0;
    logic signed [31:0] i_new_value = '0;
    logic signed [31:0] i_search_key = '0;
    logic               o_valid;
    logic        [1:0]  o_status;
    logic signed [31:0] o_entry_value;
    logic               o_entry_valid;
    logic               o_last;
    logic        [4:0]  o_occupancy;

    list_scoreboard sb = new();
    int             items_sent;
    bit             filling = 1'b1;

    bounded_circular_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_new_value   (i_new_value),
        .i_search_key  (i_search_key),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_entry_valid (o_entry_valid),
        .o_last        (o_last),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d beats still outstanding", sb.expected_beats.size());
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            sb.check_beat(o_status, o_entry_value, o_entry_valid, o_last, o_occupancy);
    end

    // Hold the command until the block takes it
    task automatic send_item(input logic [2:0] kind, input logic signed [31:0] value,
                             input logic signed [31:0] key);
        start        <= 1'b1;
        i_kind       <= kind;
        i_new_value  <= value;
        i_search_key <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(kind, value, key);
        items_sent++;
    endtask

    task automatic idle_gaps(input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($urandom_range(6)) - 32'sd3;
            4:          return VAL_MIN;
            5:          return VAL_MAX;
            default:    return $urandom;
        endcase
    endfunction

    // Mostly hit a stored value so searches succeed
    function automatic logic signed [31:0] pick_stored();
        if (sb.entries.size() == 0 || $urandom_range(3) == 0) return pick_value();
        return sb.entries[$urandom_range(sb.entries.size() - 1)];
    endfunction

    task automatic run_random(input int count, input int idle_pct);
        int                 r;
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic signed [31:0] key;
        for (int n = 0; n < count; n++) begin
            idle_gaps(idle_pct);
            if (sb.entries.size() >= LIST_CAP && $urandom_range(2) == 0) filling = 1'b0;
            if (sb.entries.size() == 0 && $urandom_range(2) == 0) filling = 1'b1;
            r = $urandom_range(99);
            if (r < 8) kind = K_LIST;
            else if (r < 10) kind = K_UNUSED;
            else if (r < (filling ? 70 : 40)) kind = 3'($urandom_range(2));
            else kind = 3'($urandom_range(5, 3));
            value = (kind == K_DEL_VALUE) ? pick_stored() : pick_value();
            key   = (kind == K_INS_AFTER) ? pick_stored() : $urandom;
            send_item(kind, value, key);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty-list corner cases, then first inserts, insert-after hit and miss, a delete miss and an unused kind
        send_item(K_LIST, $urandom, $urandom);
        send_item(K_DEL_FRONT, $urandom, $urandom);
        send_item(K_DEL_BACK, $urandom, $urandom);
        send_item(K_DEL_VALUE, VAL_MIN, $urandom);
        send_item(K_INS_AFTER, 32'sd1, 32'sd1);
        send_item(K_INS_FRONT, VAL_MIN, $urandom);
        send_item(K_INS_BACK, VAL_MAX, $urandom);
        send_item(K_INS_AFTER, -32'sd1, VAL_MIN);
        send_item(K_INS_AFTER, 32'sd5, 32'sd12345);
        send_item(K_DEL_VALUE, 32'sd0, $urandom);
        send_item(K_UNUSED, $urandom, $urandom);
        // Fill to capacity with duplicates, push against the bound, then list and delete a value
        for (int i = 0; i < LIST_CAP - 3; i++)
            send_item(3'(i % 3), 32'(i % 4), -32'sd1);
        send_item(K_INS_FRONT, 32'sd7, $urandom);
        send_item(K_INS_BACK, 32'sd7, $urandom);
        send_item(K_INS_AFTER, 32'sd7, VAL_MAX);
        send_item(K_LIST, $urandom, $urandom);
        send_item(K_DEL_VALUE, 32'sd1, $urandom);

        run_random(40, 6);
        run_random(40, 48);
        run_random(40, 0);

        start <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands, checked %0d result beats, peak occupancy %0d",
                 items_sent, sb.beats_checked, sb.peak_count);
        $display("Full answers %0d, not-found answers %0d, mismatches %0d",
                 sb.full_answers, sb.miss_answers, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
